[rtl/ptz_tracking_command_defines.svh]
// Assertion macros for the tracking command block
`ifndef PTZ_TRACKING_COMMAND_DEFINES_SVH
`define PTZ_TRACKING_COMMAND_DEFINES_SVH
// Implication checked every clock, quiet during reset
`define PTZ_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication, quiet during reset
`define PTZ_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

[rtl/ptz_pkg.sv]
// Package: widths, constants and CORDIC angle table for the tracking command block
`default_nettype none
package ptz_pkg;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int TABLE_LEN = 24;
    localparam int ANGLE_MAX = 36000;
    localparam int CFG_W = 13;
    localparam logic [0:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [0:0] REG_IMAGE_HEIGHT = 1'd1;
    localparam int CW = 64;
    localparam int ZW = 32;
    localparam int PIPE_PRE = 5;

    function automatic logic [ZW-1:0] atan_entry(input int i);
        logic [ZW-1:0] t [TABLE_LEN];
        t = '{32'd294912000, 32'd174096719, 32'd91987925, 32'd46694507, 32'd23437865,
              32'd11730358, 32'd5866610, 32'd2933484, 32'd1466764, 32'd733385,
              32'd366693, 32'd183346, 32'd91673, 32'd45837, 32'd22918, 32'd11459,
              32'd5730, 32'd2865, 32'd1432, 32'd716, 32'd358, 32'd179, 32'd90, 32'd45};
        return t[i];
    endfunction
endpackage
`default_nettype wire

[rtl/ptz_cordic_stage.sv]
// One CORDIC vectoring rotation with its pipeline register
`default_nettype none
module ptz_cordic_stage import ptz_pkg::*; #(
    parameter int IDX = 0
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_vld,
    input  wire logic signed [CW-1:0] i_x,
    input  wire logic signed [CW-1:0] i_y,
    input  wire logic signed [ZW-1:0] i_z,
    output logic                      o_vld,
    output logic signed [CW-1:0]      o_x,
    output logic signed [CW-1:0]      o_y,
    output logic signed [ZW-1:0]      o_z
);
    logic signed [CW-1:0] n_x, n_y, w_xs, w_ys, w_ax, w_ay;
    logic signed [ZW-1:0] n_z;
    logic                 r_vld;
    logic signed [CW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;

    always_comb begin
        w_ax = i_x[CW-1] ? -i_x : i_x;
        w_ay = i_y[CW-1] ? -i_y : i_y;
        w_xs = i_x[CW-1] ? -(w_ax >>> IDX) : (w_ax >>> IDX);
        w_ys = i_y[CW-1] ? -(w_ay >>> IDX) : (w_ay >>> IDX);
        if (!i_y[CW-1]) begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + $signed(atan_entry(IDX));
        end else begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - $signed(atan_entry(IDX));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_vld = r_vld;
    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule
`default_nettype wire

[rtl/ptz_prep.sv]
// Front pipeline: focal length, offset scaling and CORDIC operands for one axis
`default_nettype none
module ptz_prep import ptz_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_vld,
    input  wire logic [11:0]          i_centre,
    input  wire logic [CFG_W-1:0]     i_size,
    input  wire logic [7:0]           i_zoom,
    output logic                      o_vld,
    output logic signed [CW-1:0]      o_y,
    output logic signed [CW-1:0]      o_x,
    output logic                      o_neg
);
    logic [3:0]           r_vld;
    // stage 1
    logic signed [13:0]   r1_dx;
    logic [CFG_W-1:0]     r1_size, r2_size, r3_size;
    logic [7:0]           r1_u;
    logic [7:0]           r1_u_d;
    logic                 r1_hi;
    logic [15:0]          r1_u2;
    // stage 2
    logic signed [13:0]   r2_dx, r3_dx;
    logic signed [31:0]   r2_cub, r2_lin;
    // stage 3
    logic signed [31:0]   r3_f;
    // stage 4
    logic signed [CW-1:0] r4_x, r4_y;
    logic                 r4_neg;

    logic signed [13:0]   n1_dx;
    logic signed [31:0]   n2_cub, n2_lin, w_u, w_u2;
    logic signed [CW-1:0] n4_y, n4_x;

    always_comb begin
        n1_dx = $signed({2'b00, i_centre}) - $signed({2'b00, i_size[CFG_W-1:1]});
        w_u = $signed({24'd0, r1_u});
        w_u2 = $signed({16'd0, r1_u2});
        if (r1_hi) begin
            n2_cub = 32'sd1200 * w_u2 - 32'sd68800 * w_u;
            n2_lin = 32'sd1129900 * w_u + 32'sd24487000;
        end else begin
            n2_cub = 32'sd2 * w_u2 - 32'sd300 * w_u;
            n2_lin = 32'sd44600 * w_u + 32'sd8760900;
        end
        n4_y = CW'(r3_dx) * 64'sd2540000;
        n4_x = CW'(r3_f) * $signed({51'd0, r3_size});
        if (n4_y[CW-1]) n4_y = -n4_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_vld};
        end
        r1_dx <= n1_dx;
        r1_size <= i_size;
        r1_hi <= (i_zoom > 8'd200);
        r1_u <= (i_zoom > 8'd200) ? i_zoom - 8'd200 : i_zoom;
        r1_u2 <= ((i_zoom > 8'd200) ? i_zoom - 8'd200 : i_zoom)
            * ((i_zoom > 8'd200) ? i_zoom - 8'd200 : i_zoom);
        r2_dx <= r1_dx;
        r2_size <= r1_size;
        r2_cub <= n2_cub;
        r2_lin <= n2_lin;
        // cubic term: (a u^2 - b u) * u plus linear part
        r3_f <= 32'(r2_cub * $signed({24'd0, r1_u_d})) + r2_lin;
        r3_dx <= r2_dx;
        r3_size <= r2_size;
        r4_y <= n4_y;
        r4_x <= n4_x;
        r4_neg <= r3_dx[13];
    end

    always_ff @(posedge i_clk) begin
        r1_u_d <= r1_u;
    end

    assign o_vld = r_vld[3];
    assign o_y = r4_y;
    assign o_x = r4_x;
    assign o_neg = r4_neg;
endmodule
`default_nettype wire

[rtl/ptz_axis.sv]
// One axis: operand prep, CORDIC chain and final rounding with saturation
`default_nettype none
module ptz_axis import ptz_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_vld,
    input  wire logic [11:0]       i_centre,
    input  wire logic [CFG_W-1:0]  i_size,
    input  wire logic [7:0]        i_zoom,
    input  wire logic signed [16:0] i_cur,
    output logic                   o_vld,
    output logic signed [16:0]     o_angle
);
    localparam int N = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
    localparam int LAT = 4 + N;

    logic                 p_vld, p_neg;
    logic signed [CW-1:0] p_x, p_y;
    logic                 c_vld [N+1];
    logic signed [CW-1:0] c_x [N+1];
    logic signed [CW-1:0] c_y [N+1];
    logic signed [ZW-1:0] c_z [N+1];
    logic                 r_zero [N];
    logic                 r_neg  [N];
    logic signed [16:0]   r_cur  [LAT];
    logic                 r_ovld;
    logic signed [16:0]   r_ang;
    logic signed [ZW-1:0] w_z;
    logic [16:0]          w_r;
    logic signed [18:0]   w_s;
    logic signed [16:0]   n_ang;

    ptz_prep u_prep (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(i_vld), .i_centre(i_centre),
        .i_size(i_size), .i_zoom(i_zoom), .o_vld(p_vld), .o_y(p_y), .o_x(p_x),
        .o_neg(p_neg)
    );

    assign c_vld[0] = p_vld;
    assign c_x[0] = p_x;
    assign c_y[0] = p_y;
    assign c_z[0] = '0;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_stage
            ptz_cordic_stage #(.IDX(g)) u_stage (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(c_vld[g]),
                .i_x(c_x[g]), .i_y(c_y[g]), .i_z(c_z[g]),
                .o_vld(c_vld[g+1]), .o_x(c_x[g+1]), .o_y(c_y[g+1]), .o_z(c_z[g+1])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        r_cur[0] <= i_cur;
        for (int i = 1; i < LAT; i++) r_cur[i] <= r_cur[i-1];
        r_neg[0] <= p_neg;
        for (int i = 1; i < N; i++) r_neg[i] <= r_neg[i-1];
        r_zero[0] <= (p_y == '0);
        for (int i = 1; i < N; i++) r_zero[i] <= r_zero[i-1];
    end

    always_comb begin
        w_z = c_z[N][ZW-1] ? '0 : c_z[N];
        w_r = 17'((w_z + 32'sd32768) >>> 16);
        if (r_zero[N-1]) w_r = '0;
        if (r_neg[N-1]) w_s = 19'(r_cur[LAT-1]) - $signed({2'b00, w_r});
        else w_s = 19'(r_cur[LAT-1]) + $signed({2'b00, w_r});
        if (w_s > 19'sd36000) n_ang = 17'sd36000;
        else if (w_s < -19'sd36000) n_ang = -17'sd36000;
        else n_ang = w_s[16:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            r_ovld <= c_vld[N];
        end
        r_ang <= n_ang;
    end

    assign o_vld = r_ovld;
    assign o_angle = r_ang;
endmodule
`default_nettype wire

[rtl/ptz_tracking_command.sv]
// Top level: pan/tilt/focus command pipeline
// channel  | ports                                  | handshake
// config   | i_cfg_we i_cfg_index i_cfg_data        | write when i_cfg_we
// command  | start + six field ports                | accepted when start && !busy
// result   | o_done + o_new_pan o_new_tilt o_focus  | one cycle strobe
// One item per cycle, busy is always low; each item passes the prep pipeline,
// CORDIC_STAGES rotation stages (capped at 24) and an output register.
// Reset is synchronous active low, clears valid bits and loads 1920 x 1080.
// The result side cannot stall, so nothing is ever held back.
`default_nettype none
`include "ptz_tracking_command_defines.svh"
module ptz_tracking_command import ptz_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [0:0]         i_cfg_index,
    input  wire logic [CFG_W-1:0]   i_cfg_data,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [11:0]        i_box_center_x,
    input  wire logic [11:0]        i_box_center_y,
    input  wire logic signed [16:0] i_current_pan,
    input  wire logic signed [16:0] i_current_tilt,
    input  wire logic [7:0]         i_current_zoom,
    input  wire logic [15:0]        i_object_distance,
    output logic                    o_done,
    output logic signed [16:0]      o_new_pan,
    output logic signed [16:0]      o_new_tilt,
    output logic [8:0]              o_focus_command
);
    localparam int N = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
    localparam int LAT = N + 5;

    logic [CFG_W-1:0] r_width, r_height;
    logic             w_acc, w_pv, w_tv;
    logic [8:0]       r_foc [LAT-1];
    logic [31:0]      r_q;
    logic [46:0]      w_prod;
    logic [1:0]       r_sel;
    logic [8:0]       n_foc;

    assign busy = 1'b0;
    assign w_acc = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 13'd1920;
            r_height <= 13'd1080;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_width <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ptz_axis #(.CORDIC_STAGES(CORDIC_STAGES)) u_pan (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(w_acc), .i_centre(i_box_center_x),
        .i_size(r_width), .i_zoom(i_current_zoom), .i_cur(i_current_pan),
        .o_vld(w_pv), .o_angle(o_new_pan)
    );
    ptz_axis #(.CORDIC_STAGES(CORDIC_STAGES)) u_tilt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(w_acc), .i_centre(i_box_center_y),
        .i_size(r_height), .i_zoom(i_current_zoom), .i_cur(i_current_tilt),
        .o_vld(w_tv), .o_angle(o_new_tilt)
    );

    // q / 1e6 as ((q >> 6) * ceil(2^37 / 15625)) >> 37, exact for q < 2^29
    assign w_prod = {24'd0, r_q[28:6]} * 47'd8796094;

    // focus: -3d^2+72000d-75e6 over 1e6, d in 1500..9000
    always_comb begin
        case (r_sel)
            2'd1: n_foc = 9'd0;
            2'd2: n_foc = 9'd190;
            default: n_foc = w_prod[45:37];
        endcase
    end

    logic [31:0] w_pos;
    assign w_pos = 32'd72000 * {16'd0, i_object_distance} - 32'd75000000;
    logic [31:0] w_sq;
    assign w_sq = 32'd3 * ({16'd0, i_object_distance} * {16'd0, i_object_distance});

    always_ff @(posedge i_clk) begin
        r_q <= w_pos - w_sq;
        r_sel <= (i_object_distance < 16'd1500) ? 2'd1 :
                 (i_object_distance > 16'd9000) ? 2'd2 : 2'd0;
        r_foc[0] <= n_foc;
        for (int i = 1; i < LAT - 1; i++) r_foc[i] <= r_foc[i-1];
    end

    assign o_done = w_pv;
    assign o_focus_command = r_foc[LAT-2];

    `PTZ_ASSERT_IMP(a_axes_sync, i_clk, i_rst_n, 1'b1, w_pv == w_tv)
    `PTZ_ASSERT_IMP(a_pan_range, i_clk, i_rst_n, o_done,
        (o_new_pan <= 17'sd36000) && (o_new_pan >= -17'sd36000))
    `PTZ_ASSERT_IMP(a_focus_range, i_clk, i_rst_n, o_done, o_focus_command <= 9'd330)
endmodule
`default_nettype wire

[tb/tb_ptz_tracking_command.sv]
// Testbench for ptz_tracking_command: directed and random words checked against a local predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_ptz_tracking_command import ptz_pkg::*;;

    typedef struct {
        logic [11:0]        cx;
        logic [11:0]        cy;
        logic signed [16:0] pan;
        logic signed [16:0] tilt;
        logic [7:0]         zoom;
        logic [15:0]        range_mm;
    } cmd_t;

    typedef struct {
        logic signed [16:0] pan;
        logic signed [16:0] tilt;
        logic [8:0]         focus;
    } ptz_cmd_t;

    localparam int TRACK_LATENCY = CORDIC_STAGES_DEF + PIPE_PRE;
    localparam int CYCLE_LIMIT   = 200000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [0:0]         i_cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               start = 1'b0;
    logic               busy;
    logic [11:0]        i_box_center_x = '0;
    logic [11:0]        i_box_center_y = '0;
    logic signed [16:0] i_current_pan = '0;
    logic signed [16:0] i_current_tilt = '0;
    logic [7:0]         i_current_zoom = '0;
    logic [15:0]        i_object_distance = '0;
    logic               o_done;
    logic signed [16:0] o_new_pan;
    logic signed [16:0] o_new_tilt;
    logic [8:0]         o_focus_command;

    ptz_tracking_command u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .start             (start),
        .busy              (busy),
        .i_box_center_x    (i_box_center_x),
        .i_box_center_y    (i_box_center_y),
        .i_current_pan     (i_current_pan),
        .i_current_tilt    (i_current_tilt),
        .i_current_zoom    (i_current_zoom),
        .i_object_distance (i_object_distance),
        .o_done            (o_done),
        .o_new_pan         (o_new_pan),
        .o_new_tilt        (o_new_tilt),
        .o_focus_command   (o_focus_command)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    cmd_t     cmd_q[$];
    ptz_cmd_t cmd_exp_q[$];
    longint   cfg_width = 1920;
    longint   cfg_height = 1080;
    int       mismatches = 0;
    int       cycles = 0;
    int       burst_left = 0;
    int       gap_left = 0;
    bit       drain_hold = 1'b0;
    cmd_t     drv_cmd;

    function automatic longint shift_mag(longint v, int s);
        if (v < 0)
            return -longint'(64'(-v) >> s);
        return longint'(64'(v) >> s);
    endfunction

    function automatic longint focal_um(logic [7:0] zoom);
        longint z;
        z = zoom;
        if (z <= 200)
            return 2 * z * z * z - 300 * z * z + 44600 * z + 8760900;
        z = z - 200;
        return 1200 * z * z * z - 68800 * z * z + 1129900 * z + 24487000;
    endfunction

    // atan2 in hundredths of a degree via vectoring CORDIC on |y|
    function automatic longint offset_angle(longint y, longint x);
        bit     neg;
        int     n;
        longint z;
        longint xs;
        longint ys;
        longint r;
        neg = y < 0;
        n = CORDIC_STAGES_DEF > TABLE_LEN ? TABLE_LEN : CORDIC_STAGES_DEF;
        z = 0;
        if (neg)
            y = -y;
        if (y == 0)
            return 0;
        for (int i = 0; i < n; i++) begin
            xs = shift_mag(x, i);
            ys = shift_mag(y, i);
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + longint'(atan_entry(i));
            end else begin
                x = x - ys; y = y + xs; z = z - longint'(atan_entry(i));
            end
        end
        if (z < 0)
            z = 0;
        r = longint'((64'(z) + 64'd32768) >> 16);
        return neg ? -r : r;
    endfunction

    function automatic logic signed [16:0] steer_angle(logic [11:0] centre, longint size,
                                                      logic [7:0] zoom,
                                                      logic signed [16:0] cur);
        longint dx;
        longint s;
        dx = longint'(centre) - (size >> 1);
        s = longint'(cur) + offset_angle(dx * 2540000, focal_um(zoom) * size);
        if (s > ANGLE_MAX) s = ANGLE_MAX;
        if (s < -ANGLE_MAX) s = -ANGLE_MAX;
        return 17'(s);
    endfunction

    function automatic logic [8:0] focus_step(logic [15:0] range_mm);
        longint d;
        d = range_mm;
        if (d < 1500)
            return 9'd0;
        if (d > 9000)
            return 9'd190;
        return 9'((-3 * d * d + 72000 * d - 75000000) / 1000000);
    endfunction

    function automatic ptz_cmd_t track_cmd(cmd_t c);
        ptz_cmd_t r;
        r.pan   = steer_angle(c.cx, cfg_width, c.zoom, c.pan);
        r.tilt  = steer_angle(c.cy, cfg_height, c.zoom, c.tilt);
        r.focus = focus_step(c.range_mm);
        return r;
    endfunction

    function automatic cmd_t rand_cmd();
        cmd_t c;
        c.cx   = ($urandom_range(0, 3) == 0) ? 12'($urandom) :
                 12'($urandom_range(0, 2 * 1024) + cfg_width / 2 - 1024);
        c.cy   = ($urandom_range(0, 3) == 0) ? 12'($urandom) :
                 12'($urandom_range(0, 2 * 512) + cfg_height / 2 - 512);
        c.pan  = ($urandom_range(0, 7) == 0) ? 17'($urandom) :
                 17'(int'($urandom_range(0, 72000)) - 36000);
        c.tilt = ($urandom_range(0, 7) == 0) ? 17'($urandom) :
                 17'(int'($urandom_range(0, 72000)) - 36000);
        c.zoom = 8'($urandom);
        c.range_mm = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                     16'($urandom_range(1000, 9500));
        return c;
    endfunction

    function automatic cmd_t mk_cmd(int cx, int cy, int pan, int tilt, int zoom, int range_mm);
        cmd_t c;
        c.cx = 12'(cx); c.cy = 12'(cy); c.pan = 17'(pan); c.tilt = 17'(tilt);
        c.zoom = 8'(zoom); c.range_mm = 16'(range_mm);
        return c;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy)
                cmd_exp_q.push_back(track_cmd(drv_cmd));
            if (drain_hold && cmd_exp_q.size() == 0 && !(start && !busy))
                drain_hold = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (drain_hold || cmd_q.size() == 0) begin
                start <= 1'b0;
            end else begin
                drv_cmd = cmd_q.pop_front();
                i_box_center_x    <= drv_cmd.cx;
                i_box_center_y    <= drv_cmd.cy;
                i_current_pan     <= drv_cmd.pan;
                i_current_tilt    <= drv_cmd.tilt;
                i_current_zoom    <= drv_cmd.zoom;
                i_object_distance <= drv_cmd.range_mm;
                start <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    if ($urandom_range(0, 9) == 0)
                        drain_hold = 1'b1;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        ptz_cmd_t e;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL ptz_tracking_command");
            $finish;
        end else if (i_rst_n && o_done) begin
            if (cmd_exp_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: pan %0d tilt %0d focus %0d",
                             o_new_pan, o_new_tilt, o_focus_command);
            end else begin
                e = cmd_exp_q.pop_front();
                if (o_new_pan !== e.pan || o_new_tilt !== e.tilt
                        || o_focus_command !== e.focus) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                 e.pan, e.tilt, e.focus,
                                 o_new_pan, o_new_tilt, o_focus_command);
                end
            end
        end
    end

    task automatic wait_idle();
        while (cmd_q.size() != 0 || start || cmd_exp_q.size() != 0)
            @(posedge i_clk);
        repeat (TRACK_LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, int val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_W'(val);
        if (idx == REG_IMAGE_WIDTH)
            cfg_width = val & 13'h1FFF;
        else
            cfg_height = val & 13'h1FFF;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int w_set[6] = '{4096, 1, 0, 8191, 640, 1920};
        int h_set[6] = '{4096, 1, 0, 8191, 480, 1080};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extremes at reset sizes
        cmd_q.push_back(mk_cmd(960, 540, 0, 0, 0, 0));
        cmd_q.push_back(mk_cmd(0, 0, 0, 0, 0, 1499));
        cmd_q.push_back(mk_cmd(4095, 4095, 0, 0, 255, 1500));
        cmd_q.push_back(mk_cmd(0, 4095, 36000, -36000, 200, 9000));
        cmd_q.push_back(mk_cmd(4095, 0, -36000, 36000, 201, 9001));
        cmd_q.push_back(mk_cmd(4095, 4095, 35990, 35990, 0, 65535));
        cmd_q.push_back(mk_cmd(0, 0, -35990, -35990, 0, 4500));
        cmd_q.push_back(mk_cmd(1000, 600, 65535, -65536, 100, 12000));
        cmd_q.push_back(mk_cmd(900, 500, -65536, 65535, 255, 6000));
        cmd_q.push_back(mk_cmd(961, 541, 0, 0, 128, 3000));
        cmd_q.push_back(mk_cmd(959, 539, 0, 0, 1, 7500));
        cmd_q.push_back(mk_cmd(2730, 1365, 12345, -12345, 170, 8999));
        cmd_q.push_back(mk_cmd(1365, 2730, -1, 1, 85, 1501));
        for (int i = 0; i < 100; i++)
            cmd_q.push_back(rand_cmd());
        drain_hold = 1'b1;
        wait_idle();

        for (int p = 0; p < 6; p++) begin
            write_reg(REG_IMAGE_WIDTH, w_set[p]);
            write_reg(REG_IMAGE_HEIGHT, h_set[p]);
            cmd_q.push_back(mk_cmd(0, 0, 0, 0, 0, 0));
            cmd_q.push_back(mk_cmd(4095, 4095, 36000, -36000, 255, 65535));
            cmd_q.push_back(mk_cmd(w_set[p] / 2, h_set[p] / 2, 0, 0, 200, 5000));
            for (int i = 0; i < 100; i++)
                cmd_q.push_back(rand_cmd());
            wait_idle();
        end

        if (mismatches == 0 && cmd_exp_q.size() == 0)
            $display("PASS ptz_tracking_command");
        else
            $display("FAIL ptz_tracking_command");
        $finish;
    end

endmodule
`default_nettype wire

[ptz_tracking_command.f]
+incdir+rtl
rtl/ptz_pkg.sv
rtl/ptz_cordic_stage.sv
rtl/ptz_prep.sv
rtl/ptz_axis.sv
rtl/ptz_tracking_command.sv
tb/tb_ptz_tracking_command.sv
